>>> hdl/deq_pkg.sv
// Shared types, codes and constants of the double-ended queue.
`default_nettype none

package deq_pkg;

    // Default number of cells in the row.
    localparam int unsigned DEPTH_DEFAULT = 16;

    // Widths of the payload fields.
    localparam int unsigned DATA_W = 32;
    localparam int unsigned REQ_W  = 2;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned OCC_W  = 5;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_POP_REAR   = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Word returned by a pop from an empty queue.
    localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

    // Qualified operations handed from the control to the cell row.
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
    } deq_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/deq_cell.sv
// One cell of the queue row: holds one word and trades it with its neighbours.
`default_nettype none

module deq_cell #(
    parameter int unsigned CNT_W = 5,
    parameter int unsigned IDX   = 0
) (
    input  wire                        clk,
    input  wire deq_pkg::deq_ctrl_t    ctrl,
    input  wire  [CNT_W-1:0]           count,
    input  wire  [deq_pkg::DATA_W-1:0] left_data,
    input  wire  [deq_pkg::DATA_W-1:0] right_data,
    input  wire  [deq_pkg::DATA_W-1:0] push_value,
    output logic [deq_pkg::DATA_W-1:0] data,
    output logic [deq_pkg::DATA_W-1:0] rear_data
);

    // This cell is written by a rear push when the count equals its position,
    // and it holds the rear entry when the count is one past its position.
    localparam logic [CNT_W-1:0] WR_POS = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] RD_POS = CNT_W'(IDX + 1);

    logic [deq_pkg::DATA_W-1:0] data_reg;
    logic [deq_pkg::DATA_W-1:0] data_next;

    // A front push moves every word one cell towards the rear; a front pop
    // moves every word one cell towards the front.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push_front)
        begin
            data_next = left_data;
        end
        else if (ctrl.pop_front)
        begin
            data_next = right_data;
        end
        else if (ctrl.push_rear && (count == WR_POS))
        begin
            data_next = push_value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // The word is offered to the rear select tree only by the rear cell.
    assign data      = data_reg;
    assign rear_data = (count == RD_POS) ? data_reg : '0;

endmodule

`default_nettype wire

>>> hdl/deq_chain.sv
// Row of queue cells with the front tap and the rear select tree.
`default_nettype none

module deq_chain #(
    parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT,
    parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  wire                        clk,
    input  wire deq_pkg::deq_ctrl_t    ctrl,
    input  wire  [CNT_W-1:0]           count,
    input  wire  [deq_pkg::DATA_W-1:0] push_value,
    output logic [deq_pkg::DATA_W-1:0] front_data,
    output logic [deq_pkg::DATA_W-1:0] rear_data
);

    logic [deq_pkg::DATA_W-1:0] cell_data [DEPTH];
    logic [deq_pkg::DATA_W-1:0] cell_rear [DEPTH];

    // The row itself: the first cell takes the pushed word from the left,
    // the last cell keeps its own word when the row moves to the front.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [deq_pkg::DATA_W-1:0] left_w;
        logic [deq_pkg::DATA_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = push_value;
        end
        else
        begin : g_inner_left
            assign left_w = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = cell_data[i];
        end
        else
        begin : g_inner_right
            assign right_w = cell_data[i+1];
        end

        deq_cell #(
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count),
            .left_data  (left_w),
            .right_data (right_w),
            .push_value (push_value),
            .data       (cell_data[i]),
            .rear_data  (cell_rear[i])
        );
    end

    // The front entry always sits in the first cell.
    assign front_data = cell_data[0];

    // At most one cell offers its word, so an OR over the row selects it.
    always_comb
    begin
        rear_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_data = rear_data | cell_rear[i];
        end
    end

endmodule

`default_nettype wire

>>> hdl/double_ended_queue_top.sv
// Double-ended queue of 32-bit words: control, cell row and result register.
//
// Requests arrive on the s_axis channel: s_axis_tuser carries the request
// kind (push front, push rear, pop front, pop rear) and s_axis_tdata the word
// to push. Each request gives exactly one result on the m_axis channel: the
// popped word and the occupancy after the request in m_axis_tdata, and the
// status (ok, pop on empty, push on full) in m_axis_tuser.
// A pop from an empty queue returns all ones; a push into a full queue is
// dropped and reported. Pushes return a zero word.
// The result is registered at the accepting edge and shown on m_axis straight after it.
// Throughput is one request per cycle while results are taken: the whole cell
// row moves, or the rear cell is written, in the cycle of the transfer, and a
// rear pop is read through the select tree over the row in that same cycle.
// The result register accepts a new request in the cycle its content leaves;
// when the receiver stalls, the result holds and s_axis_tready drops until
// it is taken.
// Reset empties the queue and clears the result valid flag; the cell contents
// are left as they are and are never read before being written again.
`default_nettype none

module double_ended_queue_top #(
    parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,  // [31:0] push_value
    input  wire  [1:0]  s_axis_tuser,  // [1:0] req_type
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] pop_value, [36:32] occupancy, rest zero
    output logic [1:0]  m_axis_tuser   // [1:0] status
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    logic                        accept;
    logic                        full;
    logic                        empty;
    logic [deq_pkg::REQ_W-1:0]   req_type;
    deq_pkg::deq_ctrl_t          ctrl;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [CNT_W+deq_pkg::OCC_W-1:0] occ_wide;
    logic [deq_pkg::DATA_W-1:0]  front_data;
    logic [deq_pkg::DATA_W-1:0]  rear_data;
    logic [deq_pkg::DATA_W-1:0]  value_next;
    logic [deq_pkg::STAT_W-1:0]  status_next;
    logic                        out_valid_reg;
    logic [deq_pkg::DATA_W-1:0]  pop_value_reg;
    logic [deq_pkg::STAT_W-1:0]  status_reg;
    logic [deq_pkg::OCC_W-1:0]   occupancy_reg;

    // A request is taken whenever the result register is free or drains now.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign req_type      = s_axis_tuser;
    assign full          = (count_reg == FULL_COUNT);
    assign empty         = (count_reg == '0);

    // Qualify the request against the fill state of the queue.
    always_comb
    begin
        ctrl.push_front = accept && (req_type == deq_pkg::REQ_PUSH_FRONT) && !full;
        ctrl.push_rear  = accept && (req_type == deq_pkg::REQ_PUSH_REAR) && !full;
        ctrl.pop_front  = accept && (req_type == deq_pkg::REQ_POP_FRONT) && !empty;
        ctrl.pop_rear   = accept && (req_type == deq_pkg::REQ_POP_REAR) && !empty;
    end

    // Entry count after the request.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push_front || ctrl.push_rear)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop_front || ctrl.pop_rear)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign occ_wide = {{deq_pkg::OCC_W{1'b0}}, count_next};

    // The row of cells holding the queued words.
    deq_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_chain (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count_reg),
        .push_value (s_axis_tdata),
        .front_data (front_data),
        .rear_data  (rear_data)
    );

    // Result word and status for the request.
    always_comb
    begin
        value_next  = '0;
        status_next = deq_pkg::ST_OK;
        case (req_type)
            deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_REAR:
            begin
                if (full)
                begin
                    status_next = deq_pkg::ST_FULL;
                end
            end
            deq_pkg::REQ_POP_FRONT:
            begin
                if (empty)
                begin
                    value_next  = deq_pkg::EMPTY_WORD;
                    status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    value_next = front_data;
                end
            end
            deq_pkg::REQ_POP_REAR:
            begin
                if (empty)
                begin
                    value_next  = deq_pkg::EMPTY_WORD;
                    status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    value_next = rear_data;
                end
            end
            default:
            begin
                value_next  = '0;
                status_next = deq_pkg::ST_OK;
            end
        endcase
    end

    // Control state: entry count and result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded on every accepted transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pop_value_reg <= value_next;
            status_reg    <= status_next;
            occupancy_reg <= occ_wide[deq_pkg::OCC_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, occupancy_reg, pop_value_reg};
    assign m_axis_tuser  = status_reg;

endmodule

`default_nettype wire

>>> hdl/deq_checker.sv
// Port-level checks on the double-ended queue and their binding to the top.
`default_nettype none

module deq_checker #(
    parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [1:0]  s_axis_tuser,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata,
    input wire [1:0]  m_axis_tuser
);

    localparam logic [deq_pkg::OCC_W-1:0] FULL_OCC = deq_pkg::OCC_W'(DEPTH);

    // A stalled result stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Every accepted request shows its result in the next cycle, and a push
    // always returns a zero word.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=>
            m_axis_tvalid &&
            (($past(s_axis_tuser) == deq_pkg::REQ_POP_FRONT) ||
             ($past(s_axis_tuser) == deq_pkg::REQ_POP_REAR) ||
             (m_axis_tdata[31:0] == '0)))
        else $error("accepted request gave no result or a nonzero push word");

    // A pop on an empty queue returns all ones and leaves the queue empty.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == deq_pkg::ST_EMPTY) |->
            (m_axis_tdata[31:0] == deq_pkg::EMPTY_WORD) && (m_axis_tdata[36:32] == '0))
        else $error("empty pop result wrong");

    // A refused push reports a full queue and a zero word.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == deq_pkg::ST_FULL) |->
            (m_axis_tdata[36:32] == FULL_OCC) && (m_axis_tdata[31:0] == '0))
        else $error("full push result wrong");

    // Padding bits of the result are always zero, and no status beyond full appears.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[39:37] == 3'b000) && (m_axis_tuser != 2'd3))
        else $error("result padding or status out of range");

endmodule

bind double_ended_queue_top deq_checker #(
    .DEPTH (DEPTH)
) u_deq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> tb/sv/tb_double_ended_queue_top.sv
// Self-checking testbench for the double-ended queue: directed, full, back-pressure and random tests.
module tb_double_ended_queue_top;

    localparam int unsigned DEPTH      = deq_pkg::DEPTH_DEFAULT;
    localparam int          IDLE_LIMIT = 2000;
    localparam int          IDLE_PCT   = 18;

    // One result as the queue should report it.
    typedef struct {
        logic [deq_pkg::DATA_W-1:0] pop_value;
        logic [deq_pkg::STAT_W-1:0] status;
        logic [deq_pkg::OCC_W-1:0]  occupancy;
    } deq_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [39:0] m_axis_tdata;
    wire  [1:0]  m_axis_tuser;

    // Shadow copy of the queue, updated as each request transfer is accepted.
    logic [deq_pkg::DATA_W-1:0] shadow_cells [DEPTH];
    int unsigned       shadow_head = 0;
    int unsigned       shadow_tail = 0;
    int unsigned       shadow_count = 0;

    deq_result_t expected_results [$];
    int          err_count = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;
    int          rx_hold_len = 0;
    int          rx_hold_left = 0;

    double_ended_queue_top #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    // Free-running clock with a period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the result of one request and moves the shadow queue on.
    function automatic deq_result_t deque_predict(logic [deq_pkg::REQ_W-1:0] kind,
                                                  logic [deq_pkg::DATA_W-1:0] word);
        deq_result_t res;
        res.pop_value = '0;
        res.status    = deq_pkg::ST_OK;
        if (kind == deq_pkg::REQ_PUSH_FRONT || kind == deq_pkg::REQ_PUSH_REAR)
        begin
            if (shadow_count >= DEPTH)
                res.status = deq_pkg::ST_FULL;
            else if (kind == deq_pkg::REQ_PUSH_FRONT)
            begin
                shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
                shadow_cells[shadow_head] = word;
                shadow_count++;
            end
            else
            begin
                shadow_cells[shadow_tail] = word;
                shadow_tail = (shadow_tail + 1 >= DEPTH) ? 0 : shadow_tail + 1;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
            begin
                res.pop_value = deq_pkg::EMPTY_WORD;
                res.status    = deq_pkg::ST_EMPTY;
            end
            else if (kind == deq_pkg::REQ_POP_FRONT)
            begin
                res.pop_value = shadow_cells[shadow_head];
                shadow_head = (shadow_head + 1 >= DEPTH) ? 0 : shadow_head + 1;
                shadow_count--;
            end
            else
            begin
                shadow_tail = (shadow_tail == 0) ? DEPTH - 1 : shadow_tail - 1;
                res.pop_value = shadow_cells[shadow_tail];
                shadow_count--;
            end
        end
        res.occupancy = shadow_count[deq_pkg::OCC_W-1:0];
        return res;
    endfunction

    // Offers one request, now and then after idle cycles when not calm, and records
    // its expected result once the transfer is accepted. The valid is left
    // high on return.
    task automatic send_request(logic [deq_pkg::REQ_W-1:0] kind,
                                logic [deq_pkg::DATA_W-1:0] word);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_results.push_back(deque_predict(kind, word));
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // Picks a word, now and then one of the extremes of the field.
    function automatic logic [deq_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Pops on empty at both ends, pushes of the extreme words and pops of each kind.
    task automatic test_directed();
        send_request(deq_pkg::REQ_POP_FRONT, 32'h1234_5678);
        send_request(deq_pkg::REQ_POP_REAR, 32'hFFFF_FFFF);
        send_request(deq_pkg::REQ_PUSH_FRONT, 32'h8000_0000);
        send_request(deq_pkg::REQ_PUSH_REAR, 32'h7FFF_FFFF);
        send_request(deq_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(deq_pkg::REQ_PUSH_REAR, 32'h0000_0000);
        send_request(deq_pkg::REQ_POP_FRONT, 32'h0);
        send_request(deq_pkg::REQ_POP_REAR, 32'h0);
        send_request(deq_pkg::REQ_POP_REAR, 32'h0);
        send_request(deq_pkg::REQ_POP_FRONT, 32'h0);
        send_request(deq_pkg::REQ_POP_FRONT, 32'h0);
        wait_drained();
    endtask

    // Fills the queue, tries both pushes when full, then frees one slot, refills it and pops from the front.
    task automatic test_full();
        for (int i = 0; i < DEPTH; i++)
            send_request(i[0] ? deq_pkg::REQ_PUSH_REAR : deq_pkg::REQ_PUSH_FRONT, $urandom);
        send_request(deq_pkg::REQ_PUSH_FRONT, 32'hA5A5_A5A5);
        send_request(deq_pkg::REQ_PUSH_REAR, 32'h5A5A_5A5A);
        send_request(deq_pkg::REQ_POP_REAR, 32'h0);
        send_request(deq_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(deq_pkg::REQ_POP_FRONT, 32'h0);
        wait_drained();
    endtask

    // Holds the receiver off for a long stretch while requests keep coming,
    // so that the result register fills and the input stalls.
    task automatic test_backpressure();
        rx_hold_len = 150;
        for (int i = 0; i < 20; i++)
            send_request(deq_pkg::REQ_W'($urandom_range(3)), pick_word());
        wait_drained();
    endtask

    // Random walk over the fill level: segments lean towards pushes or pops, or
    // neither, so that both the full and the empty queue are reached repeatedly.
    task automatic test_random(int n_items);
        int sent = 0;
        int seg = 0;
        int seg_len;
        int push_pct;
        logic [deq_pkg::REQ_W-1:0] kind;
        while (sent < n_items)
        begin
            seg_len = $urandom_range(20, 80);
            case ($urandom_range(2))
                0: push_pct = 15;
                1: push_pct = 50;
                default: push_pct = 85;
            endcase
            // One stretch runs with neither side idling.
            calm = (seg == 6 || seg == 7);
            for (int i = 0; i < seg_len && sent < n_items; i++)
            begin
                if ($urandom_range(99) < push_pct)
                    kind = $urandom_range(1) ? deq_pkg::REQ_PUSH_REAR
                                             : deq_pkg::REQ_PUSH_FRONT;
                else
                    kind = $urandom_range(1) ? deq_pkg::REQ_POP_REAR
                                             : deq_pkg::REQ_POP_FRONT;
                send_request(kind, pick_word());
                sent++;
            end
            seg++;
        end
        calm = 1'b0;
        wait_drained();
    endtask

    // Result receiver: random stalls, long hold-offs on request, none when calm.
    always @(posedge clk)
    begin
        if (rx_hold_len > 0)
        begin
            rx_hold_left = rx_hold_len;
            rx_hold_len  = 0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (calm)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // Compares each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        deq_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding: data %h status %0d",
                       m_axis_tdata, m_axis_tuser);
                err_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata[31:0] !== want.pop_value)
                begin
                    $error("pop_value: expected %h, got %h", want.pop_value,
                           m_axis_tdata[31:0]);
                    err_count++;
                end
                if (m_axis_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tdata[36:32] !== want.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy,
                           m_axis_tdata[36:32]);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full();
        test_backpressure();
        test_random(1660);
        repeat (5) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            err_count++;
        end
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
hdl/deq_pkg.sv
hdl/deq_cell.sv
hdl/deq_chain.sv
hdl/double_ended_queue_top.sv
hdl/deq_checker.sv
tb/sv/tb_double_ended_queue_top.sv
